// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/hrt_pkg.sv =====
package hrt_pkg;

    // Width of the Content-Length and body byte counters.
    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    localparam int OUT_LEN_BITS = 16;
    localparam logic [3:0] NAME_LEN = 4'd14;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_END     = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        PH_METHOD = 4'd0,
        PH_PATH   = 4'd1,
        PH_QKEY   = 4'd2,
        PH_QVAL   = 4'd3,
        PH_PROTO  = 4'd4,
        PH_HKEY   = 4'd5,
        PH_HVAL   = 4'd6,
        PH_BKEY   = 4'd7,
        PH_BVAL   = 4'd8,
        PH_FINISH = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    typedef enum logic [3:0] {
        TAG_NONE  = 4'd0,
        TAG_METH  = 4'd1,
        TAG_PATH  = 4'd2,
        TAG_QKEY  = 4'd3,
        TAG_QVAL  = 4'd4,
        TAG_HKEY  = 4'd5,
        TAG_HVAL  = 4'd6,
        TAG_BKEY  = 4'd7,
        TAG_BVAL  = 4'd8
    } tag_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_US    = 8'h5F;

    // One result word, as the core hands it to the output buffer.
    typedef struct packed {
        tag_t                    field_tag;
        logic [7:0]              out_byte;
        logic                    byte_valid;
        logic                    pair_end;
        logic                    parse_error;
        logic                    request_done;
        logic [OUT_LEN_BITS-1:0] content_length;
    } hrt_result_t;

    // Outcome of one step of the percent decoder.
    typedef struct packed {
        logic       emit;
        logic [7:0] dec_byte;
        esc_phase_t phase;
        logic [3:0] high;
    } decode_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

endpackage

// ===== design/hrt_core.sv =====
module hrt_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  hrt_pkg::cmd_t        cmd,
    input  logic [7:0]           in_byte,
    output hrt_pkg::hrt_result_t result
);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33) && (c <= 8'd126) && !is_alnum(c);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == hrt_pkg::CH_SP) || (c == hrt_pkg::CH_TAB);
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return (c >= 8'd32) && (c <= 8'd126);
    endfunction

    function automatic hrt_pkg::hex_t hex_val(input logic [7:0] c);
        hrt_pkg::hex_t h;
        h.ok  = 1'b1;
        h.val = c[3:0];
        if (is_digit(c)) begin
            h.val = c[3:0];
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Characters of the header name "Content-Length".
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Percent decoder: a broken escape passes the breaking byte through.
    function automatic hrt_pkg::decode_t decode(input logic [7:0] c,
                                                input hrt_pkg::esc_phase_t ph,
                                                input logic [3:0] high);
        hrt_pkg::decode_t d;
        hrt_pkg::hex_t    h;
        h          = hex_val(c);
        d.emit     = 1'b1;
        d.dec_byte = c;
        d.phase    = hrt_pkg::ESC_IDLE;
        d.high     = high;
        if (ph == hrt_pkg::ESC_IDLE) begin
            if (c == hrt_pkg::CH_PCT) begin
                d.emit  = 1'b0;
                d.phase = hrt_pkg::ESC_HIGH;
            end
        end else if ((ph == hrt_pkg::ESC_HIGH) && h.ok) begin
            d.emit  = 1'b0;
            d.high  = h.val;
            d.phase = hrt_pkg::ESC_LOW;
        end else if ((ph == hrt_pkg::ESC_LOW) && h.ok) begin
            d.dec_byte = {high, h.val};
        end
        return d;
    endfunction

    localparam int LB = hrt_pkg::LENGTH_BITS;

    hrt_pkg::phase_t     phase_reg, phase_next;
    logic                key_ne_reg, key_ne_next;
    logic                val_ne_reg, val_ne_next;
    logic [3:0]          name_idx_reg, name_idx_next;
    logic                name_mis_reg, name_mis_next;
    logic                digits_end_reg, digits_end_next;
    logic [LB-1:0]       len_reg, len_next;
    logic [LB-1:0]       body_reg, body_next;
    hrt_pkg::esc_phase_t esc_reg, esc_next;
    logic [3:0]          esc_high_reg, esc_high_next;
    logic                err_reg, err_next;
    logic                done_reg, done_next;

    hrt_pkg::tag_t       tag;
    logic [7:0]          ob;
    logic                valid, pend, accept, bad;
    logic                new_pair, enter_hkey, length_named;
    hrt_pkg::decode_t    dec;
    logic [LB+3:0]       len_times_ten;

    assign length_named  = !name_mis_reg && (name_idx_reg == hrt_pkg::NAME_LEN);
    assign len_times_ten = {len_reg, 3'b000} + {1'b0, len_reg, 1'b0}
                         + (LB+4)'(in_byte[3:0]);

    always_comb begin
        phase_next      = phase_reg;
        key_ne_next     = key_ne_reg;
        val_ne_next     = val_ne_reg;
        name_idx_next   = name_idx_reg;
        name_mis_next   = name_mis_reg;
        digits_end_next = digits_end_reg;
        len_next        = len_reg;
        body_next       = body_reg;
        esc_next        = esc_reg;
        esc_high_next   = esc_high_reg;
        err_next        = err_reg;
        done_next       = done_reg;
        tag             = hrt_pkg::TAG_NONE;
        ob              = 8'h00;
        valid           = 1'b0;
        pend            = 1'b0;
        accept          = 1'b0;
        bad             = 1'b0;
        new_pair        = 1'b0;
        enter_hkey      = 1'b0;
        dec             = decode(in_byte, esc_reg, esc_high_reg);

        case (cmd)
            hrt_pkg::CMD_RESTART: begin
                phase_next      = hrt_pkg::PH_METHOD;
                key_ne_next     = 1'b0;
                val_ne_next     = 1'b0;
                name_idx_next   = 4'd0;
                name_mis_next   = 1'b0;
                digits_end_next = 1'b0;
                len_next        = '0;
                body_next       = '0;
                esc_next        = hrt_pkg::ESC_IDLE;
                esc_high_next   = 4'd0;
                err_next        = 1'b0;
                done_next       = 1'b0;
            end
            hrt_pkg::CMD_END: begin
                if (!err_reg && !done_reg) begin
                    if ((phase_reg == hrt_pkg::PH_BVAL) && (body_reg == len_reg)) begin
                        accept = 1'b1;
                        pend   = 1'b1;
                        tag    = hrt_pkg::TAG_BVAL;
                    end else if ((phase_reg == hrt_pkg::PH_BKEY) && !key_ne_reg) begin
                        accept = 1'b1;
                    end
                end
            end
            hrt_pkg::CMD_BYTE: begin
                if (!err_reg) begin
                    case (phase_reg)
                        hrt_pkg::PH_METHOD: begin
                            if (is_alnum(in_byte)) begin
                                tag = hrt_pkg::TAG_METH; ob = in_byte; valid = 1'b1;
                            end else if (is_blank(in_byte)) begin
                                phase_next = hrt_pkg::PH_PATH;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_PATH: begin
                            if (in_byte == hrt_pkg::CH_LF) begin
                                enter_hkey = 1'b1;
                            end else if (in_byte == hrt_pkg::CH_QM) begin
                                new_pair   = 1'b1;
                                phase_next = hrt_pkg::PH_QKEY;
                            end else if (is_alnum(in_byte) || is_punct(in_byte)) begin
                                tag = hrt_pkg::TAG_PATH; ob = in_byte; valid = 1'b1;
                            end else if (is_blank(in_byte)) begin
                                phase_next = hrt_pkg::PH_PROTO;
                            end else if (in_byte != hrt_pkg::CH_CR) begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_QKEY: begin
                            if (in_byte == hrt_pkg::CH_LF) begin
                                if (key_ne_reg) begin
                                    pend = 1'b1; tag = hrt_pkg::TAG_QVAL;
                                end
                                enter_hkey = 1'b1;
                            end else if (in_byte == hrt_pkg::CH_EQ) begin
                                phase_next = hrt_pkg::PH_QVAL;
                            end else if (is_alnum(in_byte) || (in_byte == hrt_pkg::CH_US)
                                         || (in_byte == hrt_pkg::CH_DOT)) begin
                                tag = hrt_pkg::TAG_QKEY; ob = in_byte; valid = 1'b1;
                                key_ne_next = 1'b1;
                            end else if (is_blank(in_byte)) begin
                                pend = 1'b1; tag = hrt_pkg::TAG_QVAL;
                                new_pair   = 1'b1;
                                phase_next = hrt_pkg::PH_PROTO;
                            end else if (in_byte != hrt_pkg::CH_CR) begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_QVAL: begin
                            if (in_byte == hrt_pkg::CH_LF) begin
                                pend = 1'b1; tag = hrt_pkg::TAG_QVAL;
                                enter_hkey = 1'b1;
                            end else if (in_byte == hrt_pkg::CH_AMP) begin
                                pend = 1'b1; tag = hrt_pkg::TAG_QVAL;
                                new_pair   = 1'b1;
                                phase_next = hrt_pkg::PH_QKEY;
                            end else if (is_alnum(in_byte)) begin
                                tag = hrt_pkg::TAG_QVAL; ob = in_byte; valid = 1'b1;
                                val_ne_next = 1'b1;
                            end else if (is_blank(in_byte)) begin
                                pend = 1'b1; tag = hrt_pkg::TAG_QVAL;
                                new_pair   = 1'b1;
                                phase_next = hrt_pkg::PH_PROTO;
                            end else if (in_byte != hrt_pkg::CH_CR) begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_PROTO: begin
                            if (in_byte == hrt_pkg::CH_LF) begin
                                enter_hkey = 1'b1;
                            end else if ((in_byte != hrt_pkg::CH_CR) && !is_alnum(in_byte)
                                         && !is_punct(in_byte)) begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_HKEY: begin
                            if (in_byte == hrt_pkg::CH_LF) begin
                                if (key_ne_reg) begin
                                    bad = 1'b1;
                                end else begin
                                    new_pair   = 1'b1;
                                    phase_next = hrt_pkg::PH_BKEY;
                                end
                            end else if (in_byte == hrt_pkg::CH_COLON) begin
                                if (length_named) begin
                                    len_next        = '0;
                                    digits_end_next = 1'b0;
                                end
                                phase_next = hrt_pkg::PH_HVAL;
                            end else if (is_alnum(in_byte) || is_punct(in_byte)) begin
                                tag = hrt_pkg::TAG_HKEY; ob = in_byte; valid = 1'b1;
                                key_ne_next = 1'b1;
                                if (!name_mis_reg && (name_idx_reg < hrt_pkg::NAME_LEN)
                                    && (in_byte == name_char(name_idx_reg))) begin
                                    name_idx_next = name_idx_reg + 4'd1;
                                end else begin
                                    name_mis_next = 1'b1;
                                end
                            end else if (in_byte != hrt_pkg::CH_CR) begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_HVAL: begin
                            if (in_byte == hrt_pkg::CH_LF) begin
                                pend = 1'b1; tag = hrt_pkg::TAG_HVAL;
                                enter_hkey = 1'b1;
                            end else if (is_print(in_byte)) begin
                                // Leading blanks of a header value are dropped.
                                if (val_ne_reg || !is_blank(in_byte)) begin
                                    val_ne_next = 1'b1;
                                    if (length_named && !digits_end_reg) begin
                                        if (is_digit(in_byte)) begin
                                            if (len_times_ten > (LB+4)'(hrt_pkg::LEN_MAX)) begin
                                                len_next = hrt_pkg::LEN_MAX;
                                            end else begin
                                                len_next = len_times_ten[LB-1:0];
                                            end
                                        end else begin
                                            digits_end_next = 1'b1;
                                        end
                                    end
                                    esc_next      = dec.phase;
                                    esc_high_next = dec.high;
                                    if (dec.emit) begin
                                        tag = hrt_pkg::TAG_HVAL; ob = dec.dec_byte; valid = 1'b1;
                                    end
                                end
                            end else if (in_byte != hrt_pkg::CH_CR) begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_BKEY: begin
                            if (body_reg < hrt_pkg::LEN_MAX) begin
                                body_next = body_reg + LB'(1);
                            end
                            if (in_byte == hrt_pkg::CH_LF) begin
                                if (key_ne_reg) begin
                                    pend = 1'b1; tag = hrt_pkg::TAG_BVAL;
                                end
                                done_next  = 1'b1;
                                phase_next = hrt_pkg::PH_FINISH;
                            end else if (in_byte == hrt_pkg::CH_EQ) begin
                                phase_next = hrt_pkg::PH_BVAL;
                            end else if (is_alnum(in_byte) || (in_byte == hrt_pkg::CH_US)) begin
                                tag = hrt_pkg::TAG_BKEY; ob = in_byte; valid = 1'b1;
                                key_ne_next = 1'b1;
                            end else if (in_byte != hrt_pkg::CH_CR) begin
                                bad = 1'b1;
                            end
                        end
                        hrt_pkg::PH_BVAL: begin
                            if (body_reg < hrt_pkg::LEN_MAX) begin
                                body_next = body_reg + LB'(1);
                            end
                            if (in_byte == hrt_pkg::CH_LF) begin
                                pend = 1'b1; tag = hrt_pkg::TAG_BVAL;
                                done_next  = 1'b1;
                                phase_next = hrt_pkg::PH_FINISH;
                            end else if (in_byte == hrt_pkg::CH_AMP) begin
                                pend = 1'b1; tag = hrt_pkg::TAG_BVAL;
                                new_pair   = 1'b1;
                                phase_next = hrt_pkg::PH_BKEY;
                            end else if ((in_byte == hrt_pkg::CH_PLUS) || is_alnum(in_byte)
                                         || is_punct(in_byte)) begin
                                val_ne_next = 1'b1;
                                if (in_byte == hrt_pkg::CH_PLUS) begin
                                    dec = decode(hrt_pkg::CH_SP, esc_reg, esc_high_reg);
                                end
                                esc_next      = dec.phase;
                                esc_high_next = dec.high;
                                if (dec.emit) begin
                                    tag = hrt_pkg::TAG_BVAL; ob = dec.dec_byte; valid = 1'b1;
                                end
                            end else if (in_byte != hrt_pkg::CH_CR) begin
                                bad = 1'b1;
                            end
                        end
                        default: begin
                            // Finished, or an unused phase code: bytes are ignored.
                        end
                    endcase

                    if (new_pair || enter_hkey) begin
                        key_ne_next   = 1'b0;
                        val_ne_next   = 1'b0;
                        esc_next      = hrt_pkg::ESC_IDLE;
                        esc_high_next = 4'd0;
                    end
                    if (enter_hkey) begin
                        name_idx_next = 4'd0;
                        name_mis_next = 1'b0;
                        phase_next    = hrt_pkg::PH_HKEY;
                    end
                    if (bad) begin
                        err_next = 1'b1;
                        tag      = hrt_pkg::TAG_NONE;
                        valid    = 1'b0;
                        pend     = 1'b0;
                    end
                end
            end
            default: begin
                // Unknown command: state holds.
            end
        endcase

        result.field_tag      = tag;
        result.out_byte       = valid ? ob : 8'h00;
        result.byte_valid     = valid;
        result.pair_end       = pend;
        result.parse_error    = err_next;
        result.request_done   = !err_next && (done_next || accept);
        result.content_length = (32'(len_next) > 32'h0000_FFFF) ? 16'hFFFF
                                                               : 16'(32'(len_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= hrt_pkg::PH_METHOD;
            key_ne_reg     <= 1'b0;
            val_ne_reg     <= 1'b0;
            name_idx_reg   <= 4'd0;
            name_mis_reg   <= 1'b0;
            digits_end_reg <= 1'b0;
            len_reg        <= '0;
            body_reg       <= '0;
            esc_reg        <= hrt_pkg::ESC_IDLE;
            esc_high_reg   <= 4'd0;
            err_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            key_ne_reg     <= key_ne_next;
            val_ne_reg     <= val_ne_next;
            name_idx_reg   <= name_idx_next;
            name_mis_reg   <= name_mis_next;
            digits_end_reg <= digits_end_next;
            len_reg        <= len_next;
            body_reg       <= body_next;
            esc_reg        <= esc_next;
            esc_high_reg   <= esc_high_next;
            err_reg        <= err_next;
            done_reg       <= done_next;
        end
    end

endmodule

// ===== design/http_request_tokenizer_top.sv =====
// Channel   Dir  Bits                 Carries
// s_axis    in   tdata 8, tuser 2     one command word: request byte and command
// m_axis    out  tdata 32, tuser 4    one result word per command word
//
// Every accepted command word yields exactly one result word, and a new word
// can be accepted in every cycle while the skid register is empty; the parser state
// and the output buffer both register the result in the cycle of acceptance.
// Reset is synchronous and active low; it clears the parser state and the
// output buffer, and s_tready stays low until the first cycle after reset.
// A two-entry output buffer (result register plus skid register) lets the
// input side take one more word after m_tready drops.
module http_request_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte, [8] byte_valid, [9] pair_end, [10] parse_error,
    // [11] request_done, [27:12] content_length, [31:28] zero
    output logic [31:0] m_tdata,
    output logic [3:0]  m_tuser    // [3:0] field_tag
);

    hrt_pkg::hrt_result_t new_result;
    hrt_pkg::hrt_result_t out_reg, out_next;
    hrt_pkg::hrt_result_t skid_reg, skid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic                 ready_reg;
    logic                 in_accept;
    logic                 out_pop;

    assign in_accept = s_tvalid && ready_reg;
    assign out_pop   = out_valid_reg && m_tready;

    // The core holds the parser state and works out the result of the word
    // being accepted in this cycle.
    hrt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_accept),
        .cmd     (hrt_pkg::cmd_t'(s_tuser)),
        .in_byte (s_tdata),
        .result  (new_result)
    );

    // Output buffer. When the result register is full and not draining, a
    // new result parks in the skid register and input is held off until the
    // skid register empties back into the result register.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (out_pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_accept) begin
            if (out_valid_reg && !out_pop) begin
                skid_next       = new_result;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = new_result;
                out_valid_next = 1'b1;
            end
        end else if (out_pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            ready_reg      <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            ready_reg      <= !skid_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_tready = ready_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.field_tag;
    assign m_tdata  = {4'b0000, out_reg.content_length, out_reg.request_done,
                       out_reg.parse_error, out_reg.pair_end, out_reg.byte_valid,
                       out_reg.out_byte};

endmodule

// ===== design/hrt_checker.sv =====
`include "assert_macros.svh"

module hrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // A stalled result word must not change.
    `ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An error result carries no tag, no byte and no completion.
    `ASSERT_IMP(a_error_quiet, aclk, aresetn, m_tvalid && m_tdata[10], (m_tuser == 4'd0) && !m_tdata[8] && !m_tdata[9] && !m_tdata[11])

    // A byte that is not flagged valid reads as zero.
    `ASSERT_IMP(a_byte_zero, aclk, aresetn, m_tvalid && !m_tdata[8], m_tdata[7:0] == 8'h00)

    // A pair end names a value tag and never comes with a byte.
    `ASSERT_IMP(a_pair_tag, aclk, aresetn, m_tvalid && m_tdata[9], !m_tdata[8] && ((m_tuser == 4'd4) || (m_tuser == 4'd6) || (m_tuser == 4'd8)))

    // A valid byte always has a field tag, and the pad bits stay zero.
    `ASSERT_IMP(a_byte_tagged, aclk, aresetn, m_tvalid, (!m_tdata[8] || (m_tuser != 4'd0)) && (m_tdata[31:28] == 4'd0))

endmodule

bind http_request_tokenizer_top hrt_checker u_hrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/http_request_tokenizer_top_tb.sv =====
module http_request_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrt_pkg::*;

    // The fourth command code has no member in cmd_t; the block must treat it
    // as a no-op that only reports the sticky flags and the length.
    localparam logic [1:0] CMD_OTHER = 2'd3;

    // Number of random command words to generate after the directed part.
    localparam int RANDOM_WORDS = 2000;

    // Hard limit on simulated time, far above the slowest legal run.
    localparam int RUN_LIMIT_NS = 2000000;

    // -------------------------------------------------------------------------
    // Clock, reset and the ports of the block.
    // -------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic [1:0]  s_tuser  = 2'd0;    // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [7:0] out_byte, [8] byte_valid, [9] pair_end,
                                     // [10] parse_error, [11] request_done,
                                     // [27:12] content_length, [31:28] zero
    logic [3:0]  m_tuser;            // [3:0] field_tag

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    http_request_tokenizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // -------------------------------------------------------------------------
    // Character sets used to build requests.
    // -------------------------------------------------------------------------
    string length_hdr = "Content-Length";
    string alnum_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
    string hex_chars   = "0123456789abcdefABCDEF";
    string path_chars  = "ABCXYZabcxyz0189/-._~!$'()*,;:@%=&+";
    string qkey_chars  = "ABCXYZabcxyz0189_.";
    string bkey_chars  = "ABCXYZabcxyz0189_";
    string hname_chars = "ABCXYZabcxyz0189-";
    string bval_chars  = "ABCXYZabcxyz0189!$'()*,;:@%=/-._~";

    // -------------------------------------------------------------------------
    // Tokenizer state as the testbench tracks it.
    // -------------------------------------------------------------------------
    phase_t                 tk_phase;
    bit                     tk_key_seen;
    bit                     tk_val_seen;
    logic [3:0]             tk_name_idx;
    bit                     tk_name_miss;
    bit                     tk_digits_over;
    logic [LENGTH_BITS-1:0] tk_length;
    logic [LENGTH_BITS-1:0] tk_body_bytes;
    esc_phase_t             tk_esc;
    logic [3:0]             tk_esc_high;
    bit                     tk_error;
    bit                     tk_done;

    // Words waiting to be offered, and results predicted but not yet seen.
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        bit         drain;    // hold this word back until no result is pending
    } word_t;

    word_t       request_words[$];
    hrt_result_t predicted_tokens[$];

    int  total_words;
    int  words_in;
    int  results_out;
    int  pair_ends;
    int  done_results;
    int  error_results;
    int  mismatches;
    int  rx_hold_left;
    bit  rx_hold_used;
    bit  in_taken;

    // -------------------------------------------------------------------------
    // Character classes, written the way the block is meant to classify bytes.
    // -------------------------------------------------------------------------
    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alnum(logic [7:0] c);
        return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_punct(logic [7:0] c);
        return c >= 8'd33 && c <= 8'd126 && !is_alnum(c);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic bit is_print(logic [7:0] c);
        return c >= 8'd32 && c <= 8'd126;
    endfunction

    function automatic int hex_of(logic [7:0] c);
        if (is_digit(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic bit length_named();
        return !tk_name_miss && tk_name_idx == NAME_LEN;
    endfunction

    task automatic clear_parser();
        tk_phase       = PH_METHOD;
        tk_key_seen    = 1'b0;
        tk_val_seen    = 1'b0;
        tk_name_idx    = 4'd0;
        tk_name_miss   = 1'b0;
        tk_digits_over = 1'b0;
        tk_length      = '0;
        tk_body_bytes  = '0;
        tk_esc         = ESC_IDLE;
        tk_esc_high    = 4'd0;
        tk_error       = 1'b0;
        tk_done        = 1'b0;
    endtask

    task automatic start_pair();
        tk_key_seen = 1'b0;
        tk_val_seen = 1'b0;
        tk_esc      = ESC_IDLE;
        tk_esc_high = 4'd0;
    endtask

    task automatic start_header();
        start_pair();
        tk_name_idx  = 4'd0;
        tk_name_miss = 1'b0;
        tk_phase     = PH_HKEY;
    endtask

    // One step of the percent decoder. A '%' and its first hex digit are held
    // back; a byte that breaks the escape is passed on unchanged.
    task automatic pct_step(input logic [7:0] c, output bit emit, output logic [7:0] ob);
        int h;
        h    = hex_of(c);
        emit = 1'b1;
        ob   = c;
        if (tk_esc == ESC_IDLE) begin
            if (c == CH_PCT) begin
                tk_esc = ESC_HIGH;
                emit   = 1'b0;
            end
        end else if (tk_esc == ESC_HIGH && h >= 0) begin
            tk_esc_high = h[3:0];
            tk_esc      = ESC_LOW;
            emit        = 1'b0;
        end else if (tk_esc == ESC_LOW && h >= 0) begin
            tk_esc = ESC_IDLE;
            ob     = {tk_esc_high, h[3:0]};
        end else begin
            tk_esc = ESC_IDLE;
        end
    endtask

    // Works out the result word that one accepted command word must produce,
    // and advances the tracked tokenizer state.
    task automatic tokenize(input logic [1:0] cmd, input logic [7:0] c,
                            output hrt_result_t r);
        bit         valid;
        bit         pend;
        bit         accept;
        bit         bad;
        bit         emit;
        tag_t       tag;
        logic [7:0] ob;
        longint     acc;
        valid  = 1'b0;
        pend   = 1'b0;
        accept = 1'b0;
        bad    = 1'b0;
        tag    = TAG_NONE;
        ob     = 8'h00;
        if (cmd == CMD_RESTART) begin
            clear_parser();
        end else if (cmd == CMD_END) begin
            // The end command only reports; it never changes the state.
            if (!tk_error && !tk_done) begin
                if (tk_phase == PH_BVAL && tk_body_bytes == tk_length) begin
                    accept = 1'b1;
                    pend   = 1'b1;
                    tag    = TAG_BVAL;
                end else if (tk_phase == PH_BKEY && !tk_key_seen) begin
                    accept = 1'b1;
                end
            end
        end else if (cmd == CMD_BYTE && !tk_error) begin
            case (tk_phase)
                PH_METHOD: begin
                    if (is_alnum(c)) begin
                        tag = TAG_METH; ob = c; valid = 1'b1;
                    end else if (is_blank(c)) begin
                        tk_phase = PH_PATH;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_PATH: begin
                    if (c == CH_LF) begin
                        start_header();
                    end else if (c == CH_QM) begin
                        start_pair();
                        tk_phase = PH_QKEY;
                    end else if (is_alnum(c) || is_punct(c)) begin
                        tag = TAG_PATH; ob = c; valid = 1'b1;
                    end else if (is_blank(c)) begin
                        tk_phase = PH_PROTO;
                    end else if (c != CH_CR) begin
                        bad = 1'b1;
                    end
                end
                PH_QKEY: begin
                    if (c == CH_LF) begin
                        if (tk_key_seen) begin
                            pend = 1'b1; tag = TAG_QVAL;
                        end
                        start_header();
                    end else if (c == CH_EQ) begin
                        tk_phase = PH_QVAL;
                    end else if (is_alnum(c) || c == CH_US || c == CH_DOT) begin
                        tag = TAG_QKEY; ob = c; valid = 1'b1; tk_key_seen = 1'b1;
                    end else if (is_blank(c)) begin
                        pend = 1'b1; tag = TAG_QVAL;
                        start_pair();
                        tk_phase = PH_PROTO;
                    end else if (c != CH_CR) begin
                        bad = 1'b1;
                    end
                end
                PH_QVAL: begin
                    if (c == CH_LF) begin
                        pend = 1'b1; tag = TAG_QVAL;
                        start_header();
                    end else if (c == CH_AMP) begin
                        pend = 1'b1; tag = TAG_QVAL;
                        start_pair();
                        tk_phase = PH_QKEY;
                    end else if (is_alnum(c)) begin
                        tag = TAG_QVAL; ob = c; valid = 1'b1; tk_val_seen = 1'b1;
                    end else if (is_blank(c)) begin
                        pend = 1'b1; tag = TAG_QVAL;
                        start_pair();
                        tk_phase = PH_PROTO;
                    end else if (c != CH_CR) begin
                        bad = 1'b1;
                    end
                end
                PH_PROTO: begin
                    if (c == CH_LF) begin
                        start_header();
                    end else if (c != CH_CR && !is_alnum(c) && !is_punct(c)) begin
                        bad = 1'b1;
                    end
                end
                PH_HKEY: begin
                    if (c == CH_LF) begin
                        // An empty header line opens the body.
                        if (tk_key_seen) begin
                            bad = 1'b1;
                        end else begin
                            start_pair();
                            tk_phase = PH_BKEY;
                        end
                    end else if (c == CH_COLON) begin
                        if (length_named()) begin
                            tk_length      = '0;
                            tk_digits_over = 1'b0;
                        end
                        tk_phase = PH_HVAL;
                    end else if (is_alnum(c) || is_punct(c)) begin
                        tag = TAG_HKEY; ob = c; valid = 1'b1; tk_key_seen = 1'b1;
                        if (!tk_name_miss && tk_name_idx < NAME_LEN
                                && c == length_hdr[tk_name_idx]) begin
                            tk_name_idx = tk_name_idx + 4'd1;
                        end else begin
                            tk_name_miss = 1'b1;
                        end
                    end else if (c != CH_CR) begin
                        bad = 1'b1;
                    end
                end
                PH_HVAL: begin
                    if (c == CH_LF) begin
                        pend = 1'b1; tag = TAG_HVAL;
                        start_header();
                    end else if (is_print(c)) begin
                        // Leading blanks of the value are dropped silently.
                        if (tk_val_seen || !is_blank(c)) begin
                            tk_val_seen = 1'b1;
                            if (length_named() && !tk_digits_over) begin
                                if (is_digit(c)) begin
                                    acc = longint'(tk_length) * 10 + (c - "0");
                                    tk_length = (acc > longint'(LEN_MAX)) ? LEN_MAX
                                                : acc[LENGTH_BITS-1:0];
                                end else begin
                                    tk_digits_over = 1'b1;
                                end
                            end
                            pct_step(c, emit, ob);
                            if (emit) begin
                                tag = TAG_HVAL; valid = 1'b1;
                            end
                        end
                    end else if (c != CH_CR) begin
                        bad = 1'b1;
                    end
                end
                PH_BKEY, PH_BVAL: begin
                    if (tk_body_bytes != LEN_MAX) tk_body_bytes = tk_body_bytes + 1'b1;
                    if (tk_phase == PH_BKEY) begin
                        if (c == CH_LF) begin
                            if (tk_key_seen) begin
                                pend = 1'b1; tag = TAG_BVAL;
                            end
                            tk_done  = 1'b1;
                            tk_phase = PH_FINISH;
                        end else if (c == CH_EQ) begin
                            tk_phase = PH_BVAL;
                        end else if (is_alnum(c) || c == CH_US) begin
                            tag = TAG_BKEY; ob = c; valid = 1'b1; tk_key_seen = 1'b1;
                        end else if (c != CH_CR) begin
                            bad = 1'b1;
                        end
                    end else begin
                        if (c == CH_LF) begin
                            pend = 1'b1; tag = TAG_BVAL;
                            tk_done  = 1'b1;
                            tk_phase = PH_FINISH;
                        end else if (c == CH_AMP) begin
                            pend = 1'b1; tag = TAG_BVAL;
                            start_pair();
                            tk_phase = PH_BKEY;
                        end else if (c == CH_PLUS || is_alnum(c) || is_punct(c)) begin
                            tk_val_seen = 1'b1;
                            pct_step((c == CH_PLUS) ? CH_SP : c, emit, ob);
                            if (emit) begin
                                tag = TAG_BVAL; valid = 1'b1;
                            end
                        end else if (c != CH_CR) begin
                            bad = 1'b1;
                        end
                    end
                end
                default: begin
                    // Once the body line has ended, bytes are ignored.
                end
            endcase
            if (bad) begin
                tk_error = 1'b1;
                tag      = TAG_NONE;
                valid    = 1'b0;
                pend     = 1'b0;
            end
        end
        if (!valid) ob = 8'h00;
        r.field_tag      = tag;
        r.out_byte       = ob;
        r.byte_valid     = valid;
        r.pair_end       = pend;
        r.parse_error    = tk_error;
        r.request_done   = !tk_error && (tk_done || accept);
        r.content_length = tk_length;
    endtask

    // -------------------------------------------------------------------------
    // Stimulus building blocks.
    // -------------------------------------------------------------------------
    task automatic push_word(logic [1:0] cmd, logic [7:0] data, bit drain);
        word_t w;
        w.cmd   = cmd;
        w.data  = data;
        w.drain = drain;
        request_words.push_back(w);
    endtask

    task automatic push_byte(logic [7:0] data);
        push_word(CMD_BYTE, data, 1'b0);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_eol();
        if ($urandom_range(0, 2) != 0) push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    function automatic logic [7:0] pick(string chars);
        return chars[$urandom_range(0, chars.len() - 1)];
    endfunction

    // The Content-Length line: mostly exact, sometimes a near-miss name, a
    // signed or oversized value, or a value that stops at a non-digit.
    task automatic push_length_header(int body_len);
        int v;
        case ($urandom_range(0, 9))
            0:       push_text("Content-Lengthx");
            1:       push_text("content-length");
            2:       push_text("Content-Lengt");
            default: push_text(length_hdr);
        endcase
        push_byte(CH_COLON);
        repeat ($urandom_range(0, 2)) push_byte(CH_SP);
        v = $urandom_range(0, 9);
        if (v == 0) begin
            push_text("99999999");
        end else if (v == 1) begin
            push_byte(CH_PLUS);
            push_text($sformatf("%0d", body_len));
        end else if (v == 2) begin
            push_text($sformatf("%0d", body_len + 1));
        end else begin
            push_text($sformatf("%0d", body_len));
            if (v == 3) push_text("x7");
        end
        push_eol();
    endtask

    // One request: restart, request line, headers, body, then the end
    // command. Well formed in most cases, with one byte broken now and then.
    task automatic queue_request(bit drain);
        byte unsigned body[$];
        int           first;
        int           n;
        int           hcount;
        int           len_at;
        int           ending;
        int           r;
        first = request_words.size();
        push_word(CMD_RESTART, 8'($urandom_range(0, 255)), drain);

        repeat ($urandom_range(1, 6)) push_byte(pick(alnum_chars));
        push_byte(CH_SP);
        push_byte("/");
        repeat ($urandom_range(0, 6)) push_byte(pick(path_chars));
        if ($urandom_range(0, 1) != 0) begin
            push_byte(CH_QM);
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                if (k != 0) push_byte(CH_AMP);
                repeat ($urandom_range(0, 4)) push_byte(pick(qkey_chars));
                if (k < n - 1 || $urandom_range(0, 3) != 0) begin
                    push_byte(CH_EQ);
                    repeat ($urandom_range(0, 4)) push_byte(pick(alnum_chars));
                end
            end
        end
        if ($urandom_range(0, 3) != 0) push_text(" HTTP/1.1");
        push_eol();

        // The body is built first so that its length can go into the header.
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            if (k != 0) body.push_back(CH_AMP);
            repeat ($urandom_range(0, 4)) body.push_back(pick(bkey_chars));
            if ($urandom_range(0, 4) != 0) begin
                body.push_back(CH_EQ);
                repeat ($urandom_range(0, 6)) begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        body.push_back(CH_PCT);
                        body.push_back(pick(hex_chars));
                        body.push_back(pick(hex_chars));
                    end else if (r == 1) begin
                        body.push_back(CH_PCT);
                        if ($urandom_range(0, 1) != 0) body.push_back(pick(hex_chars));
                        body.push_back("G");
                    end else if (r == 2) begin
                        body.push_back(CH_PLUS);
                    end else begin
                        body.push_back(pick(bval_chars));
                    end
                end
            end
        end
        ending = $urandom_range(0, 2);
        if (ending == 2) body.push_back(CH_CR);
        if (ending != 0) body.push_back(CH_LF);

        hcount = $urandom_range(0, 3);
        len_at = ($urandom_range(0, 3) != 0) ? $urandom_range(0, hcount) : -1;
        for (int k = 0; k <= hcount; k++) begin
            if (k == len_at) push_length_header(body.size());
            if (k < hcount) begin
                repeat ($urandom_range(1, 8)) push_byte(pick(hname_chars));
                push_byte(CH_COLON);
                repeat ($urandom_range(0, 2)) push_byte(CH_SP);
                repeat ($urandom_range(0, 8)) begin
                    r = $urandom_range(0, 7);
                    if (r == 0) begin
                        push_byte(CH_PCT);
                        push_byte(pick(hex_chars));
                        push_byte(pick(hex_chars));
                    end else if (r == 1) begin
                        push_byte(CH_PCT);
                        push_byte("g");
                    end else begin
                        push_byte(8'($urandom_range(32, 126)));
                    end
                end
                push_eol();
            end
        end
        push_eol();
        foreach (body[i]) push_byte(body[i]);

        // Bytes after a finished body are ignored by the block.
        if (ending != 0 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));

        push_word(CMD_END, 8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 3) == 0) push_word(CMD_END, 8'h00, 1'b0);
        if ($urandom_range(0, 11) == 0) push_word(CMD_OTHER, 8'($urandom_range(0, 255)), 1'b0);

        // A broken request: one word after the restart gets a random byte.
        if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(first + 1, request_words.size() - 1);
            request_words[r].data = 8'($urandom_range(0, 255));
        end
    endtask

    // -------------------------------------------------------------------------
    // Idle rates. The run is split in thirds by words accepted: the sender
    // idles rarely and the receiver often, then the other way round, and in
    // the last third neither side idles.
    // -------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        if (words_in < total_words / 3) return 17;
        if (words_in < 2 * total_words / 3) return 57;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (words_in < total_words / 3) return 57;
        if (words_in < 2 * total_words / 3) return 17;
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on result word %0d: %s is %0h, expected %0h",
                     results_out, what, got, want);
    endtask

    // -------------------------------------------------------------------------
    // Driver. Inputs change on the falling edge only. A word stays on the bus
    // until it has been taken; a word marked for draining is held back until
    // every predicted result has arrived. During the long receiver hold the
    // sender keeps offering words so that the output buffer fills up and
    // s_tready drops.
    // -------------------------------------------------------------------------
    always @(negedge aclk) begin
        word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (request_words.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (request_words[0].drain && predicted_tokens.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (rx_hold_left == 0
                         && $urandom_range(0, 99) < sender_idle_pct()) begin
                s_tvalid <= 1'b0;
            end else begin
                w = request_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.data;
                s_tuser  <= w.cmd;
            end
        end
    end

    // Receiver. Once a few hundred results have come, m_tready is held low
    // for a long stretch that this process counts down on its own.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else if (!rx_hold_used && results_out >= 300) begin
            rx_hold_used = 1'b1;
            rx_hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // -------------------------------------------------------------------------
    // Monitor. Sampled on the rising edge: an accepted command word is run
    // through the predictor at once, and an accepted result word is checked
    // field by field against the oldest prediction.
    // -------------------------------------------------------------------------
    always @(posedge aclk) begin
        hrt_result_t want;
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tokenize(s_tuser, s_tdata, want);
                predicted_tokens.push_back(want);
                words_in++;
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                results_out++;
                if (predicted_tokens.size() == 0) begin
                    report_mismatch("unexpected result word", m_tdata, 32'h0);
                end else begin
                    want = predicted_tokens.pop_front();
                    if (want.pair_end) pair_ends++;
                    if (want.request_done) done_results++;
                    if (want.parse_error) error_results++;
                    if (m_tuser !== want.field_tag)
                        report_mismatch("field_tag", m_tuser, want.field_tag);
                    if (m_tdata[7:0] !== want.out_byte)
                        report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
                    if (m_tdata[8] !== want.byte_valid)
                        report_mismatch("byte_valid", m_tdata[8], want.byte_valid);
                    if (m_tdata[9] !== want.pair_end)
                        report_mismatch("pair_end", m_tdata[9], want.pair_end);
                    if (m_tdata[10] !== want.parse_error)
                        report_mismatch("parse_error", m_tdata[10], want.parse_error);
                    if (m_tdata[11] !== want.request_done)
                        report_mismatch("request_done", m_tdata[11], want.request_done);
                    if (m_tdata[27:12] !== want.content_length)
                        report_mismatch("content_length", m_tdata[27:12],
                                        want.content_length);
                    if (m_tdata[31:28] !== 4'h0)
                        report_mismatch("unused upper bits", m_tdata[31:28], 4'h0);
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Main sequence: build all stimulus, reset, let the driver run dry, wait
    // for the last result and a short tail, then give the verdict.
    // -------------------------------------------------------------------------
    initial begin
        int directed_words;
        clear_parser();

        // Directed words. A tiny request with an empty path line, a header
        // whose value starts with a broken escape, and a body whose value has
        // a '+' and a valid escape. The end command before the line break is
        // refused because the body is longer than the (zero) length. After
        // the line break the request is finished, so a stray byte is ignored.
        // Then the unknown command, and a request that fails on its first
        // byte and stays failed for the bytes and the end command after it.
        push_word(CMD_RESTART, 8'h00, 1'b0);
        push_text("M \nx:%G\n\nk=+%41");
        push_word(CMD_END, 8'h00, 1'b0);
        push_byte(CH_LF);
        push_byte("z");
        push_word(CMD_END, 8'h00, 1'b0);
        push_word(CMD_OTHER, 8'hFF, 1'b0);
        push_word(CMD_RESTART, 8'hFF, 1'b0);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_word(CMD_END, 8'h00, 1'b0);
        directed_words = request_words.size();

        // Random part: mostly well-formed requests, with bursts of raw noise.
        // The first random request waits for the directed results to drain.
        queue_request(1'b1);
        while (request_words.size() - directed_words < RANDOM_WORDS) begin
            if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(5, 20)) begin
                    if ($urandom_range(0, 9) == 0)
                        push_word(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                                  1'b0);
                    else
                        push_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                queue_request($urandom_range(0, 11) == 0);
            end
        end
        total_words = request_words.size();

        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (request_words.size() != 0 || s_tvalid) @(posedge aclk);
        while (predicted_tokens.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Run covered %0d command words and %0d result words, including",
                 words_in, results_out);
        $display("%0d pair ends, %0d accepted-request results, %0d error results.",
                 pair_ends, done_results, error_results);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: the run is far shorter than this even with every stall.
    initial begin
        #RUN_LIMIT_NS;
        $display("Timeout with %0d results still outstanding.", predicted_tokens.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
